// File: rtl/core/absent_index_enumerator_assert.svh
// Assertion macros for the absent index enumerator checker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef ABSENT_INDEX_ENUMERATOR_ASSERT_SVH
`define ABSENT_INDEX_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AIE_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AIE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/aie_pkg.sv
// Shared types and constants for the absent index enumerator.
// No dependencies.
`timescale 1ns / 1ps

package aie_pkg;

    localparam int RANGE_SIZE_DEF = 1024;
    localparam int WORD_W         = 32;
    localparam int WORD_LOG       = 5;
    localparam int VALUE_W        = 10;
    localparam int EP_W           = 11;

    localparam logic [EP_W-1:0] EP_RESET = 11'd1024;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] index;
        logic               found;
    } t_out_item;

    typedef struct packed {
        logic mark;
        logic sweep;
        logic cursor_clr;
        logic rd;
        logic miss;
        logic eval;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic cur_ge_end;
        logic eval_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/absent_index_enumerator.sv
// Top level of the absent index enumerator: controller plus datapath.
// Depends on aie_pkg, aie_ctrl and aie_datapath.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_item  (aie_pkg::t_in_item)
//   out       output     o_out_valid / i_out_stall  o_out_item (aie_pkg::t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (end_point)
//
// Mark and unused codes leave the controller in S_IDLE; clear sweeps all ceil(RANGE_SIZE/32) bitmap words.
// Fetch runs S_RD then S_EVAL for each 32-bit bitmap word read (one memory read
//   and one priority-encode step), then S_PUSH; S_RD goes to S_PUSH if range is used up.
// After reset a clearing pass over ceil(RANGE_SIZE/32) bitmap words (32 by default) runs
//   with o_in_stall high; configuration writes are taken throughout.
// A held result in the output register does not block marks or clears.
`timescale 1ns / 1ps

module absent_index_enumerator #(
    parameter int RANGE_SIZE = aie_pkg::RANGE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  aie_pkg::t_in_item        i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output aie_pkg::t_out_item       o_out_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [aie_pkg::EP_W-1:0] i_cfg_data
);

    aie_pkg::t_dp_cmd    cmd;
    aie_pkg::t_dp_status status;
    logic                cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    aie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    aie_datapath #(
        .RANGE_SIZE (RANGE_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: rtl/core/aie_ctrl.sv
// Controller state machine for the absent index enumerator.
// Depends on aie_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps

module aie_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_operation,
    input  aie_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output aie_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_RD    = 5'b00100,
        S_EVAL  = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        aie_pkg::OP_MARK: begin
                            o_cmd.mark = 1'b1;
                        end
                        aie_pkg::OP_FETCH: begin
                            n_state = S_RD;
                        end
                        aie_pkg::OP_CLEAR: begin
                            o_cmd.cursor_clr = 1'b1;
                            n_state          = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                if (i_status.cur_ge_end) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_PUSH;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.eval_done ? S_PUSH : S_RD;
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/aie_datapath.sv
// Datapath for the absent index enumerator: bitmap memory, cursor, scan
// logic, range register and output register. Depends on aie_pkg.
`timescale 1ns / 1ps

module aie_datapath #(
    parameter int RANGE_SIZE = aie_pkg::RANGE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aie_pkg::t_dp_cmd            i_cmd,
    output aie_pkg::t_dp_status         o_status,
    input  aie_pkg::t_in_item           i_in_item,
    input  logic                        i_cfg_we,
    input  logic [aie_pkg::EP_W-1:0]    i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output aie_pkg::t_out_item          o_out_item
);

    localparam int CW = $clog2(RANGE_SIZE + 1);
    localparam int NW = (RANGE_SIZE + aie_pkg::WORD_W - 1) / aie_pkg::WORD_W;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [31:0] RANGE32 = 32'(RANGE_SIZE);
    localparam logic [aie_pkg::WORD_W-1:0] ONE_W = aie_pkg::WORD_W'(1);

    logic [aie_pkg::WORD_W-1:0]  r_mem [NW];
    logic [aie_pkg::WORD_W-1:0]  r_rdata;
    logic [CW-1:0]               r_cursor;
    logic [aie_pkg::EP_W-1:0]    r_end_point;
    logic [AW-1:0]               r_sweep;
    aie_pkg::t_out_item          r_res;
    logic                        r_out_valid;
    aie_pkg::t_out_item          r_out_item;

    logic [31:0]                 ep32;
    logic [31:0]                 end32;
    logic [31:0]                 c32;
    logic [31:0]                 val32;
    logic [31:0]                 base32;
    logic [31:0]                 nx32;
    logic [aie_pkg::WORD_W-1:0]  low_mask;
    logic [aie_pkg::WORD_W-1:0]  free_bits;
    logic [aie_pkg::WORD_LOG-1:0] pos;
    logic                        has_zero;
    logic                        hit;
    logic                        mark_ok;

    assign ep32   = 32'(r_end_point);
    assign end32  = (ep32 > RANGE32) ? RANGE32 : ep32;
    assign c32    = 32'(r_cursor);
    assign val32  = 32'(i_in_item.value);
    assign mark_ok = val32 < end32;

    // scan window: bits below the cursor count as taken
    assign base32    = c32 & ~32'(aie_pkg::WORD_W - 1);
    assign low_mask  = (ONE_W << c32[aie_pkg::WORD_LOG-1:0]) - ONE_W;
    assign free_bits = ~(r_rdata | low_mask);
    assign has_zero  = |free_bits;

    always_comb begin
        pos = '0;
        for (int i = aie_pkg::WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                pos = aie_pkg::WORD_LOG'(i);
            end
        end
    end

    assign nx32 = has_zero ? (base32 + 32'(pos)) : (base32 + 32'(aie_pkg::WORD_W));
    assign hit  = nx32 < end32;

    assign o_status.sweep_last = (r_sweep == AW'(NW - 1));
    assign o_status.cur_ge_end = (c32 >= end32);
    assign o_status.eval_done  = !hit || has_zero;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[r_sweep] <= '0;
        end else if (i_cmd.mark && mark_ok) begin
            r_mem[AW'(val32 >> aie_pkg::WORD_LOG)][val32[aie_pkg::WORD_LOG-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[AW'(c32 >> aie_pkg::WORD_LOG)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_sweep     <= '0;
            r_end_point <= aie_pkg::EP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cursor_clr) begin
                r_cursor <= '0;
            end else if (i_cmd.eval) begin
                if (!hit) begin
                    r_cursor <= CW'(end32);
                end else if (has_zero) begin
                    r_cursor <= CW'(nx32 + 32'd1);
                end else begin
                    r_cursor <= CW'(nx32);
                end
            end
            if (i_cmd.sweep) begin
                r_sweep <= o_status.sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_cfg_we) begin
                r_end_point <= i_cfg_data;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.miss || (i_cmd.eval && !hit)) begin
            r_res <= '0;
        end else if (i_cmd.eval && has_zero) begin
            r_res.index <= aie_pkg::VALUE_W'(nx32);
            r_res.found <= 1'b1;
        end
        if (i_cmd.push) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/core/aie_checker.sv
// Port-level assertions for the absent index enumerator, bound to the top.
// Depends on aie_pkg and absent_index_enumerator_assert.svh.
`timescale 1ns / 1ps
`include "absent_index_enumerator_assert.svh"

module aie_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input aie_pkg::t_in_item        i_in_item,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input aie_pkg::t_out_item       o_out_item
);

    `AIE_CHECK_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item), "stalled out item changed")
    `AIE_CHECK_NOW(a_miss_zero, o_out_valid && !o_out_item.found,
        o_out_item.index == '0, "exhausted item has nonzero index")
    `AIE_CHECK_NEXT(a_fetch_busy,
        i_in_valid && !o_in_stall && (i_in_item.operation == aie_pkg::OP_FETCH),
        o_in_stall, "fetch did not stall input")
    `AIE_CHECK_NOW(a_out_from_fetch, $rose(o_out_valid), $past(o_in_stall),
        "out item without fetch in progress")

endmodule

bind absent_index_enumerator aie_checker u_aie_checker (.*);
